FILE: sv/sprm_pkg.sv
package sprm_pkg;

    // Fixed widths of the result fields and of the decay register
    localparam int OUT_W   = 16;
    localparam int DECAY_W = 16;

    // Decay after reset, about 0.85 in unsigned Q0.16
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd55706;

    // Channel lanes
    localparam int NUM_CH   = 2;
    localparam int CH_LEFT  = 0;
    localparam int CH_RIGHT = 1;

    // Held meters
    localparam int NUM_METERS   = 4;
    localparam int METER_PEAK_L = 0;
    localparam int METER_PEAK_R = 1;
    localparam int METER_RMS_L  = 2;
    localparam int METER_RMS_R  = 3;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_MUL,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_div;
        logic div_step;
        logic load_sqrt;
        logic sqrt_step;
        logic mul;
        logic update;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } sts_t;

endpackage

FILE: sv/stereo_peak_rms_meter_core.sv
// Stereo peak and RMS meter with per-block decay. Each input transaction carries one
// stereo frame of signed Q1.15 samples; frames are taken one per clock while a block
// accumulates (peak magnitude, sum of squares and frame count per channel, in a
// three-stage magnitude / square / accumulate pipeline). The frame flagged
// last_in_block closes the block: s_ready then stays low while the pipeline drains,
// then a one-bit-per-cycle restoring divider (sum / count) and a two-bits-per-cycle
// square root run, both channels in parallel, then a decay multiply and a compare.
// The compare also waits while a previous result is still waiting on m_ready.
// One result transaction is emitted per block carrying the four held meters, each
// max(block value, floor(held * decay / 65536)). Frames beyond MAX_FRAMES in a block
// are dropped but still close the block when flagged. decay_factor (unsigned Q0.16,
// reset 55706, about 0.85) is written on the cfg channel; the user must write it
// only while the meter is idle; the block itself does not enforce this.
module stereo_peak_rms_meter_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAMES  = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sprm_pkg::DECAY_W-1:0]     cfg_decay_factor,

    // frame input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]    s_right_sample,
    input  logic                             s_last_in_block,

    // meter result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sprm_pkg::OUT_W-1:0]       m_peak_left,
    output logic [sprm_pkg::OUT_W-1:0]       m_peak_right,
    output logic [sprm_pkg::OUT_W-1:0]       m_rms_left,
    output logic [sprm_pkg::OUT_W-1:0]       m_rms_right
);

    // Sum of squares width: one full-scale square per frame of a full block.
    // Capped at 64 bits, where the accumulator saturates.
    localparam int SUM_RAW = $clog2(MAX_FRAMES + 1) + 2 * SAMPLE_BITS - 2;
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    // Square root works on bit pairs, so the radicand is padded to even width.
    localparam int SQRT_STEPS = (SUM_W + (SUM_W % 2)) / 2;

    sprm_pkg::cmd_t cmd;
    sprm_pkg::sts_t sts;

    // The decay register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    sprm_ctrl #(
        .DIV_STEPS  (SUM_W),
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_last_in_block (s_last_in_block),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .sts             (sts)
    );

    // Held meters double as the output register; they change only when the
    // previous result has gone.
    sprm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAMES  (MAX_FRAMES),
        .SUM_W       (SUM_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr       (cfg_valid),
        .cfg_data     (cfg_decay_factor),
        .left_sample  (s_left_sample),
        .right_sample (s_right_sample),
        .peak_left    (m_peak_left),
        .peak_right   (m_peak_right),
        .rms_left     (m_rms_left),
        .rms_right    (m_rms_right)
    );

endmodule

FILE: sv/sprm_datapath.sv
module sprm_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAMES  = 1024,
    parameter int SUM_W       = 41
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sprm_pkg::cmd_t                      cmd,
    output sprm_pkg::sts_t                      sts,
    input  logic                                cfg_wr,
    input  logic [sprm_pkg::DECAY_W-1:0]        cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       right_sample,
    output logic [sprm_pkg::OUT_W-1:0]          peak_left,
    output logic [sprm_pkg::OUT_W-1:0]          peak_right,
    output logic [sprm_pkg::OUT_W-1:0]          rms_left,
    output logic [sprm_pkg::OUT_W-1:0]          rms_right
);
    import sprm_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SQ_W   = 2 * SB - 1;
    localparam int PROD_W = 2 * SB;
    localparam int QW     = SUM_W + (SUM_W % 2);
    localparam int RT_W   = QW / 2;
    localparam int SREM_W = RT_W + 2;
    localparam int HELD_W = (SB > OUT_W) ? SB : OUT_W;
    localparam int MUL_W  = HELD_W + DECAY_W;

    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_FRAMES);
    localparam logic [HELD_W-1:0] MAG_MAX   = HELD_W'(1) << (SB - 1);

    logic [DECAY_W-1:0] decay_reg, decay_next;

    // accumulate pipeline
    logic              take;
    logic [SB-1:0]     raw      [NUM_CH];
    logic [SB-1:0]     mag_in   [NUM_CH];
    logic [SB-1:0]     mag_reg  [NUM_CH];
    logic [SB-1:0]     mag_next [NUM_CH];
    logic              st1_valid_reg, st1_valid_next;
    logic              st2_valid_reg, st2_valid_next;
    logic [PROD_W-1:0] sq_full  [NUM_CH];
    logic [SQ_W-1:0]   sq_reg   [NUM_CH];
    logic [SQ_W-1:0]   sq_next  [NUM_CH];
    logic [SB-1:0]     bmax_reg [NUM_CH];
    logic [SB-1:0]     bmax_next[NUM_CH];
    logic [SUM_W-1:0]  sum_reg  [NUM_CH];
    logic [SUM_W-1:0]  sum_next [NUM_CH];
    logic [SUM_W:0]    sum_add  [NUM_CH];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // restoring divider
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [SUM_W-1:0]  quo_reg  [NUM_CH];
    logic [SUM_W-1:0]  quo_next [NUM_CH];
    logic [CNT_W-1:0]  rem_reg  [NUM_CH];
    logic [CNT_W-1:0]  rem_next [NUM_CH];
    logic [CNT_W:0]    rem_sh   [NUM_CH];
    logic [CNT_W:0]    rem_diff [NUM_CH];
    logic [SB-1:0]     fpk_reg  [NUM_CH];
    logic [SB-1:0]     fpk_next [NUM_CH];

    // digit-by-digit square root, two bits per step
    logic [QW-1:0]     rad_reg  [NUM_CH];
    logic [QW-1:0]     rad_next [NUM_CH];
    logic [RT_W-1:0]   root_reg [NUM_CH];
    logic [RT_W-1:0]   root_next[NUM_CH];
    logic [SREM_W-1:0] srem_reg [NUM_CH];
    logic [SREM_W-1:0] srem_next[NUM_CH];
    logic [SREM_W-1:0] srem_sh  [NUM_CH];
    logic [SREM_W-1:0] trial    [NUM_CH];
    logic [SREM_W-1:0] sdiff    [NUM_CH];

    // decay and hold
    logic [MUL_W-1:0]  dprod_reg [NUM_METERS];
    logic [MUL_W-1:0]  dprod_next[NUM_METERS];
    logic [HELD_W-1:0] held_reg  [NUM_METERS];
    logic [HELD_W-1:0] held_next [NUM_METERS];
    logic [HELD_W-1:0] fresh     [NUM_METERS];
    logic [HELD_W-1:0] decayed   [NUM_METERS];

    assign raw[CH_LEFT]  = $unsigned(left_sample);
    assign raw[CH_RIGHT] = $unsigned(right_sample);
    assign take          = cmd.accept && (cnt_reg < CNT_LIMIT);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            mag_in[c]   = raw[c][SB-1] ? (~raw[c] + 1'b1) : raw[c];
            sq_full[c]  = mag_reg[c] * mag_reg[c];
            sum_add[c]  = {1'b0, sum_reg[c]} + (SUM_W + 1)'(sq_reg[c]);
            rem_sh[c]   = {rem_reg[c], quo_reg[c][SUM_W-1]};
            rem_diff[c] = rem_sh[c] - {1'b0, den_reg};
            srem_sh[c]  = {srem_reg[c][RT_W-1:0], rad_reg[c][QW-1 -: 2]};
            trial[c]    = {root_reg[c], 2'b01};
            sdiff[c]    = srem_sh[c] - trial[c];
        end
        fresh[METER_PEAK_L] = HELD_W'(fpk_reg[CH_LEFT]);
        fresh[METER_PEAK_R] = HELD_W'(fpk_reg[CH_RIGHT]);
        fresh[METER_RMS_L]  = HELD_W'(root_reg[CH_LEFT]);
        fresh[METER_RMS_R]  = HELD_W'(root_reg[CH_RIGHT]);
        for (int m = 0; m < NUM_METERS; m++) begin
            decayed[m] = dprod_reg[m][MUL_W-1:DECAY_W];
        end
    end

    always_comb begin
        decay_next     = cfg_wr ? cfg_data : decay_reg;
        st1_valid_next = take;
        st2_valid_next = st1_valid_reg;
        cnt_next       = cnt_reg;
        den_next       = den_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            mag_next[c]  = mag_reg[c];
            sq_next[c]   = sq_reg[c];
            bmax_next[c] = bmax_reg[c];
            sum_next[c]  = sum_reg[c];
            quo_next[c]  = quo_reg[c];
            rem_next[c]  = rem_reg[c];
            fpk_next[c]  = fpk_reg[c];
            rad_next[c]  = rad_reg[c];
            root_next[c] = root_reg[c];
            srem_next[c] = srem_reg[c];
        end
        for (int m = 0; m < NUM_METERS; m++) begin
            dprod_next[m] = dprod_reg[m];
            held_next[m]  = held_reg[m];
        end

        if (take) begin
            cnt_next = cnt_reg + 1'b1;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            if (take) begin
                mag_next[c] = mag_in[c];
            end
            if (st1_valid_reg) begin
                sq_next[c] = sq_full[c][SQ_W-1:0];
                if (mag_reg[c] > bmax_reg[c]) begin
                    bmax_next[c] = mag_reg[c];
                end
            end
            if (st2_valid_reg) begin
                // saturates only when the sum is a full 64 bits wide
                sum_next[c] = sum_add[c][SUM_W] ? '1 : sum_add[c][SUM_W-1:0];
            end
        end

        if (cmd.load_div) begin
            den_next = cnt_reg;
            cnt_next = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                quo_next[c]  = sum_reg[c];
                rem_next[c]  = '0;
                fpk_next[c]  = bmax_reg[c];
                sum_next[c]  = '0;
                bmax_next[c] = '0;
            end
        end

        for (int c = 0; c < NUM_CH; c++) begin
            if (cmd.div_step) begin
                if (!rem_diff[c][CNT_W]) begin
                    rem_next[c] = rem_diff[c][CNT_W-1:0];
                end else begin
                    rem_next[c] = rem_sh[c][CNT_W-1:0];
                end
                quo_next[c] = {quo_reg[c][SUM_W-2:0], ~rem_diff[c][CNT_W]};
            end
            if (cmd.load_sqrt) begin
                // empty block gives zero RMS
                rad_next[c]  = (den_reg == '0) ? '0 : QW'(quo_reg[c]);
                root_next[c] = '0;
                srem_next[c] = '0;
            end
            if (cmd.sqrt_step) begin
                if (srem_sh[c] >= trial[c]) begin
                    srem_next[c] = sdiff[c];
                    root_next[c] = {root_reg[c][RT_W-2:0], 1'b1};
                end else begin
                    srem_next[c] = srem_sh[c];
                    root_next[c] = {root_reg[c][RT_W-2:0], 1'b0};
                end
                rad_next[c] = {rad_reg[c][QW-3:0], 2'b00};
            end
        end

        for (int m = 0; m < NUM_METERS; m++) begin
            if (cmd.mul) begin
                dprod_next[m] = MUL_W'(held_reg[m]) * MUL_W'(decay_reg);
            end
            if (cmd.update) begin
                held_next[m] = (fresh[m] > decayed[m]) ? fresh[m] : decayed[m];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg     <= DECAY_RESET;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                bmax_reg[c] <= '0;
                sum_reg[c]  <= '0;
            end
            for (int m = 0; m < NUM_METERS; m++) begin
                held_reg[m] <= '0;
            end
        end else begin
            decay_reg     <= decay_next;
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            cnt_reg       <= cnt_next;
            for (int c = 0; c < NUM_CH; c++) begin
                bmax_reg[c] <= bmax_next[c];
                sum_reg[c]  <= sum_next[c];
            end
            for (int m = 0; m < NUM_METERS; m++) begin
                held_reg[m] <= held_next[m];
            end
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        for (int c = 0; c < NUM_CH; c++) begin
            mag_reg[c]  <= mag_next[c];
            sq_reg[c]   <= sq_next[c];
            quo_reg[c]  <= quo_next[c];
            rem_reg[c]  <= rem_next[c];
            fpk_reg[c]  <= fpk_next[c];
            rad_reg[c]  <= rad_next[c];
            root_reg[c] <= root_next[c];
            srem_reg[c] <= srem_next[c];
        end
        for (int m = 0; m < NUM_METERS; m++) begin
            dprod_reg[m] <= dprod_next[m];
        end
    end

    assign sts.pipe_busy = st1_valid_reg || st2_valid_reg;

    assign peak_left  = held_reg[METER_PEAK_L][OUT_W-1:0];
    assign peak_right = held_reg[METER_PEAK_R][OUT_W-1:0];
    assign rms_left   = held_reg[METER_RMS_L][OUT_W-1:0];
    assign rms_right  = held_reg[METER_RMS_R][OUT_W-1:0];

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LIMIT)
        else $error("frame count beyond block limit");

    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_valid_reg |-> $past(st1_valid_reg))
        else $error("square stage valid without magnitude stage");

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (held_reg[METER_PEAK_L] <= MAG_MAX) && (held_reg[METER_PEAK_R] <= MAG_MAX)
            && (held_reg[METER_RMS_L] <= MAG_MAX) && (held_reg[METER_RMS_R] <= MAG_MAX))
        else $error("held meter above full scale");
`endif

endmodule

FILE: sv/sprm_ctrl.sv
module sprm_ctrl #(
    parameter int DIV_STEPS  = 41,
    parameter int SQRT_STEPS = 21
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_last_in_block,
    output logic           m_valid,
    input  logic           m_ready,
    output sprm_pkg::cmd_t cmd,
    input  sprm_pkg::sts_t sts
);
    import sprm_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_last_in_block) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    cmd.load_div = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_SQRT_LOAD;
                end
            end
            ST_SQRT_LOAD: begin
                cmd.load_sqrt = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // held meters are the output register: wait until it is free
                if (!m_valid_reg || m_ready) begin
                    cmd.update   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_update_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_valid_reg || m_ready))
        else $error("meters overwritten while result pending");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_UPDATE))
        else $error("result raised outside meter update");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_div |-> !sts.pipe_busy)
        else $error("divider loaded before accumulation drained");
`endif

endmodule
